// File: rtl/rlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recursive lock table package
// Field widths, request modes, result status codes and the lookup summary
// that passes from the slot match to the count update.
// ----------------------------------------------------------------------------
package rlt_pkg;

    localparam int MODE_W   = 2;
    localparam int ID_W     = 22;
    localparam int STATUS_W = 3;
    localparam int HOLD_W   = 16;
    localparam int SLOT_W   = 4;

    localparam logic [MODE_W-1:0] MODE_INIT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOCK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNLOCK = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OTHER  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREE_UNLOCK = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd4;

    typedef struct packed {
        logic full;   // no matching slot and no free slot
        logic claim;  // a free slot was taken for this group
    } lookup_t;

endpackage

// File: rtl/rlt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recursive lock table channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rlt_req_if;
    logic                      valid;
    logic                      ready;
    logic [rlt_pkg::MODE_W-1:0] mode;
    logic [rlt_pkg::ID_W-1:0]   group_id;
    logic [rlt_pkg::ID_W-1:0]   thread_id;

    modport source (output valid, output mode, output group_id, output thread_id,
                    input ready);
    modport sink   (input valid, input mode, input group_id, input thread_id,
                    output ready);
endinterface

interface rlt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [rlt_pkg::STATUS_W-1:0] status;
    logic [rlt_pkg::HOLD_W-1:0]   hold_count;
    logic [rlt_pkg::SLOT_W-1:0]   slot_index;

    modport source (output valid, output status, output hold_count, output slot_index,
                    input ready);
    modport sink   (input valid, input status, input hold_count, input slot_index,
                    output ready);
endinterface

// File: rtl/recursive_lock_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recursive lock table
// One recursive lock per process group: slot match over all group ids,
// owner and count kept in a slot memory, one response word per request.
// ----------------------------------------------------------------------------
//   Channel  Direction  Word contents
//   req      in         mode, group_id, thread_id
//   rsp      out        status, hold_count, slot_index
//
// The slot match and memory read happen in the cycle a request is accepted;
// the count update, write-back and response follow in the next.
// One request is in flight at a time; the next may be accepted in the cycle
// the response is taken. A stalled response holds off new requests.
// Reset clears the in-use bits and the busy and response valid flags only;
// the slot memory needs no clearing.
module recursive_lock_table_top #(
    parameter int SLOTS      = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    rlt_req_if.sink   req,
    rlt_rsp_if.source rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic             accept;
    logic             busy;
    logic [IDX_W-1:0] idx;
    rlt_pkg::lookup_t lookup;

    assign req.ready = !busy && (!rsp.valid || rsp.ready);
    assign accept    = req.valid && req.ready;

    rlt_match #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .lookup_en (accept),
        .group_id  (req.group_id),
        .idx       (idx),
        .lookup    (lookup)
    );

    rlt_store #(
        .SLOTS      (SLOTS),
        .IDX_W      (IDX_W),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .idx       (idx),
        .lookup    (lookup),
        .mode      (req.mode),
        .thread_id (req.thread_id),
        .busy      (busy),
        .rsp       (rsp)
    );

endmodule

// File: rtl/rlt_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recursive lock table slot match
// Holds the in-use bits and group ids of all slots, compares a group id
// against every slot at once and claims the highest free slot on a miss.
// ----------------------------------------------------------------------------
module rlt_match #(
    parameter int SLOTS = 16,
    parameter int IDX_W = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     lookup_en,
    input  logic [rlt_pkg::ID_W-1:0] group_id,
    output logic [IDX_W-1:0]         idx,
    output rlt_pkg::lookup_t         lookup
);

    logic [SLOTS-1:0]         used_reg;
    logic [rlt_pkg::ID_W-1:0] group_reg [SLOTS];

    logic [SLOTS-1:0] hit;
    logic             any_hit;
    logic             any_free;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            hit[i] = used_reg[i] && (group_reg[i] == group_id);
        end
    end

    // Lowest matching slot wins; highest free slot is the claim candidate.
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!used_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign any_hit  = |hit;
    assign any_free = ~&used_reg;

    assign lookup.full  = !any_hit && !any_free;
    assign lookup.claim = !any_hit && any_free;
    assign idx          = any_hit ? hit_idx : free_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (lookup_en && lookup.claim)
        begin
            used_reg[free_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lookup_en && lookup.claim)
        begin
            group_reg[free_idx] <= group_id;
        end
    end

endmodule

// File: rtl/rlt_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recursive lock table count store
// Owner and count memory with a registered read, the lock/unlock update
// and the response register.
// ----------------------------------------------------------------------------
module rlt_store #(
    parameter int SLOTS      = 16,
    parameter int IDX_W      = 4,
    parameter int COUNT_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [IDX_W-1:0]           idx,
    input  rlt_pkg::lookup_t           lookup,
    input  logic [rlt_pkg::MODE_W-1:0] mode,
    input  logic [rlt_pkg::ID_W-1:0]   thread_id,
    output logic                       busy,
    rlt_rsp_if.source                  rsp
);

    localparam int ENTRY_W = rlt_pkg::ID_W + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Owner in the upper bits, count in the lower bits.
    logic [ENTRY_W-1:0] mem [SLOTS];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic                       busy_reg;
    logic [IDX_W-1:0]           idx_reg;
    rlt_pkg::lookup_t           lookup_reg;
    logic [rlt_pkg::MODE_W-1:0] mode_reg;
    logic [rlt_pkg::ID_W-1:0]   tid_reg;

    logic                         out_valid_reg;
    logic [rlt_pkg::STATUS_W-1:0] status_reg;
    logic [rlt_pkg::HOLD_W-1:0]   hold_reg;
    logic [rlt_pkg::SLOT_W-1:0]   slot_reg;

    logic [rlt_pkg::ID_W-1:0]   rd_owner;
    logic [COUNT_BITS-1:0]      cur_count;
    logic [rlt_pkg::ID_W-1:0]   owner_next;
    logic [COUNT_BITS-1:0]      count_next;
    logic [rlt_pkg::STATUS_W-1:0] status_next;
    logic                       wr_en;

    assign rd_owner = rd_data_reg[ENTRY_W-1:COUNT_BITS];
    // A freshly claimed slot starts from zero whatever the memory holds.
    assign cur_count = lookup_reg.claim ? '0 : rd_data_reg[COUNT_BITS-1:0];

    always_comb
    begin
        owner_next  = rd_owner;
        count_next  = cur_count;
        status_next = rlt_pkg::ST_OK;
        case (mode_reg)
            rlt_pkg::MODE_LOCK:
            begin
                if (cur_count == '0 || rd_owner == tid_reg)
                begin
                    if (cur_count == COUNT_MAX)
                    begin
                        status_next = rlt_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        count_next = cur_count + COUNT_BITS'(1);
                        owner_next = tid_reg;
                    end
                end
                else
                begin
                    status_next = rlt_pkg::ST_BUSY;
                end
            end
            rlt_pkg::MODE_UNLOCK:
            begin
                if (cur_count == '0)
                begin
                    status_next = rlt_pkg::ST_FREE_UNLOCK;
                end
                else
                begin
                    count_next = cur_count - COUNT_BITS'(1);
                end
            end
            default:
            begin
                status_next = rlt_pkg::ST_OK;
            end
        endcase
    end

    assign wr_en = busy_reg && !lookup_reg.full;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[idx_reg] <= {owner_next, count_next};
        end
        if (accept)
        begin
            rd_data_reg <= mem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= accept;
            if (busy_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg    <= idx;
            lookup_reg <= lookup;
            mode_reg   <= mode;
            tid_reg    <= thread_id;
        end
        if (busy_reg)
        begin
            if (lookup_reg.full)
            begin
                status_reg <= rlt_pkg::ST_FULL;
                hold_reg   <= '0;
                slot_reg   <= '0;
            end
            else
            begin
                status_reg <= status_next;
                hold_reg   <= rlt_pkg::HOLD_W'(count_next);
                slot_reg   <= rlt_pkg::SLOT_W'(idx_reg);
            end
        end
    end

    assign busy           = busy_reg;
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.hold_count = hold_reg;
    assign rsp.slot_index = slot_reg;

endmodule

// File: sim/tb_recursive_lock_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recursive lock table testbench
// Drives lock, unlock, init and other requests through the request channel
// and checks every response word against a slot table kept in the bench.
// A directed part walks the special cases and a short recursive lock run.
// The table is then filled, and random traffic follows under several idle
// and stall mixes, with one long response hold-off.
// ----------------------------------------------------------------------------
module tb_recursive_lock_table_top;

    localparam int SLOTS       = 16;
    localparam int COUNT_BITS  = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 454;

    typedef struct packed {
        logic [rlt_pkg::STATUS_W-1:0] status;
        logic [rlt_pkg::HOLD_W-1:0]   hold_count;
        logic [rlt_pkg::SLOT_W-1:0]   slot_index;
    } lock_result_t;

    class lock_table_tracker;
        bit                       used[SLOTS];
        logic [rlt_pkg::ID_W-1:0] group_of[SLOTS];
        logic [rlt_pkg::ID_W-1:0] owner_of[SLOTS];
        logic [COUNT_BITS-1:0]    count_of[SLOTS];
        lock_result_t             pending_results[$];
        int                       failures;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                used[i]     = 1'b0;
                group_of[i] = '0;
                owner_of[i] = '0;
                count_of[i] = '0;
            end
            failures = 0;
        endfunction

        // Works out the response of one accepted request and updates the table.
        function void note_request(logic [rlt_pkg::MODE_W-1:0] mode,
                                   logic [rlt_pkg::ID_W-1:0] grp,
                                   logic [rlt_pkg::ID_W-1:0] tid);
            int           hit;
            int           spare;
            lock_result_t r;
            hit   = -1;
            spare = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (used[i])
                begin
                    if (hit < 0 && group_of[i] == grp)
                        hit = i;
                end
                else
                    spare = i;
            end
            if (hit < 0 && spare >= 0)
            begin
                used[spare]     = 1'b1;
                group_of[spare] = grp;
                count_of[spare] = '0;
                hit             = spare;
            end
            if (hit < 0)
            begin
                r = '{rlt_pkg::ST_FULL, '0, '0};
            end
            else
            begin
                r.status = rlt_pkg::ST_OK;
                if (mode == rlt_pkg::MODE_LOCK)
                begin
                    if (count_of[hit] == 0 || owner_of[hit] == tid)
                    begin
                        if (count_of[hit] == {COUNT_BITS{1'b1}})
                            r.status = rlt_pkg::ST_OVERFLOW;
                        else
                        begin
                            count_of[hit] = count_of[hit] + COUNT_BITS'(1);
                            owner_of[hit] = tid;
                        end
                    end
                    else
                        r.status = rlt_pkg::ST_BUSY;
                end
                else if (mode == rlt_pkg::MODE_UNLOCK)
                begin
                    if (count_of[hit] == 0)
                        r.status = rlt_pkg::ST_FREE_UNLOCK;
                    else
                        count_of[hit] = count_of[hit] - COUNT_BITS'(1);
                end
                r.hold_count = count_of[hit][rlt_pkg::HOLD_W-1:0];
                r.slot_index = hit[rlt_pkg::SLOT_W-1:0];
            end
            pending_results.push_back(r);
        endfunction

        function void check_response(lock_result_t got);
            lock_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: response with nothing pending: status %0d count %0d slot %0d",
                         $time, got.status, got.hold_count, got.slot_index);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            if (got !== want)
            begin
                $display("%0t: mismatch: expected status %0d count %0d slot %0d,",
                         $time, want.status, want.hold_count, want.slot_index);
                $display("%0t: mismatch: got status %0d count %0d slot %0d",
                         $time, got.status, got.hold_count, got.slot_index);
                failures++;
            end
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction

        function logic [rlt_pkg::ID_W-1:0] claimed_group();
            int picks[$];
            for (int i = 0; i < SLOTS; i++)
                if (used[i])
                    picks.push_back(i);
            return group_of[picks[$urandom_range(picks.size() - 1)]];
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_off       = 1'b0;
    int   cycle_count    = 0;
    logic [rlt_pkg::ID_W-1:0] thread_pool[6];

    lock_table_tracker tracker = new();

    rlt_req_if req_ch();
    rlt_rsp_if rsp_ch();

    recursive_lock_table_top #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL recursive_lock_table_top");
            $finish;
        end
    end

    // Response side: checks each word taken, then decides ready for the next cycle.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                tracker.check_response(lock_result_t'{rsp_ch.status, rsp_ch.hold_count,
                                                      rsp_ch.slot_index});
            rsp_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(input logic [rlt_pkg::MODE_W-1:0] mode,
                                input logic [rlt_pkg::ID_W-1:0] grp,
                                input logic [rlt_pkg::ID_W-1:0] tid);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.mode      <= mode;
        req_ch.group_id  <= grp;
        req_ch.thread_id <= tid;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        tracker.note_request(mode, grp, tid);
    endtask

    task automatic random_requests(input int items);
        logic [rlt_pkg::MODE_W-1:0] mode;
        logic [rlt_pkg::ID_W-1:0]   grp;
        logic [rlt_pkg::ID_W-1:0]   tid;
        repeat (items)
        begin
            mode = rlt_pkg::MODE_W'($urandom_range(3));
            if ($urandom_range(99) < 85)
                grp = tracker.claimed_group();
            else
                grp = rlt_pkg::ID_W'($urandom_range(22'h3FFFFF));
            if ($urandom_range(99) < 75)
                tid = thread_pool[$urandom_range(5)];
            else
                tid = rlt_pkg::ID_W'($urandom_range(22'h3FFFFF));
            send_request(mode, grp, tid);
        end
    endtask

    initial
    begin
        logic [rlt_pkg::ID_W-1:0] g_low;
        logic [rlt_pkg::ID_W-1:0] g_high;
        logic [rlt_pkg::ID_W-1:0] g_deep;
        logic [rlt_pkg::ID_W-1:0] t_a;
        logic [rlt_pkg::ID_W-1:0] t_b;
        logic [rlt_pkg::ID_W-1:0] t_z;
        g_low  = '0;
        g_high = '1;
        g_deep = 22'h2AAAAA;
        t_a    = 22'h155555;
        t_b    = '1;
        t_z    = '0;
        for (int i = 0; i < 6; i++)
            thread_pool[i] = rlt_pkg::ID_W'($urandom_range(22'h3FFFFF));

        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.mode      = rlt_pkg::MODE_INIT;
        req_ch.group_id  = '0;
        req_ch.thread_id = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(rlt_pkg::MODE_INIT, g_low, t_z);
        send_request(rlt_pkg::MODE_UNLOCK, g_low, t_z);    // unlock of a free lock
        send_request(rlt_pkg::MODE_LOCK, g_low, t_a);
        send_request(rlt_pkg::MODE_LOCK, g_low, t_a);      // recursive lock by the owner
        send_request(rlt_pkg::MODE_LOCK, g_low, t_b);      // held by another thread
        send_request(rlt_pkg::MODE_UNLOCK, g_low, t_b);    // a non-owner may unlock
        send_request(rlt_pkg::MODE_OTHER, g_low, t_b);
        send_request(rlt_pkg::MODE_OTHER, g_high, t_b);    // other command still claims
        send_request(rlt_pkg::MODE_LOCK, g_high, t_z);
        send_request(rlt_pkg::MODE_UNLOCK, g_high, t_z);
        send_request(rlt_pkg::MODE_LOCK, g_high, t_a);     // free again, new owner
        send_request(rlt_pkg::MODE_UNLOCK, g_deep, t_z);   // claim by unlock

        // A short recursive run on one slot, then contention and release.
        repeat (3)
            send_request(rlt_pkg::MODE_LOCK, g_deep, t_b);
        send_request(rlt_pkg::MODE_LOCK, g_deep, t_b);
        send_request(rlt_pkg::MODE_LOCK, g_deep, t_a);
        send_request(rlt_pkg::MODE_UNLOCK, g_deep, t_a);
        send_request(rlt_pkg::MODE_LOCK, g_deep, t_b);

        // Claim the remaining slots with every mode, then overrun the table.
        for (int k = 0; k < SLOTS - 3; k++)
            send_request(k[rlt_pkg::MODE_W-1:0],
                         rlt_pkg::ID_W'($urandom_range(22'h3FFFFF)),
                         rlt_pkg::ID_W'($urandom_range(22'h3FFFFF)));
        send_request(rlt_pkg::MODE_LOCK, rlt_pkg::ID_W'($urandom_range(22'h3FFFFF)), t_a);
        send_request(rlt_pkg::MODE_OTHER, rlt_pkg::ID_W'($urandom_range(22'h3FFFFF)), t_b);

        fork
        begin
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
        end
        join_none
        random_requests(PHASE_ITEMS);

        send_idle_pct = 53;
        random_requests(PHASE_ITEMS);

        send_idle_pct  = 0;
        recv_stall_pct = 53;
        random_requests(PHASE_ITEMS);

        send_idle_pct  = 37;
        recv_stall_pct = 37;
        random_requests(PHASE_ITEMS);

        req_ch.valid <= 1'b0;
        while (tracker.pending_count() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (tracker.failures == 0 && tracker.pending_count() == 0)
            $display("PASS recursive_lock_table_top");
        else
            $display("FAIL recursive_lock_table_top");
        $finish;
    end
endmodule
